/* sv/imf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package imf_pkg;

    // Record table
    localparam int DEPTH     = 64;
    localparam int REC_AW    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int REC_W     = 8 + 16 + 32;

    // Result list
    localparam int RES_DEPTH = 32;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int N_W       = $clog2(RES_DEPTH + 1);

    // Interpolation arithmetic
    localparam int TR_W      = 17;
    localparam int PR_W      = 33;
    localparam int PROD_W    = TR_W + PR_W;
    localparam int DCNT_W    = $clog2(PROD_W + 1);

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NODATA = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RS_OK     = 2'd0,
        RS_FULL   = 2'd1,
        RS_NODATA = 2'd2,
        RS_MEDIAN = 2'd3
    } t_rsel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ISCAN,
        S_ISH_RD,
        S_ISH_WR,
        S_PASS,
        S_QSCAN,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_RSCAN,
        S_RSH_RD,
        S_RSH_WR,
        S_MRD,
        S_FIN_OK,
        S_FIN_FULL,
        S_FIN_NODATA,
        S_FIN_MED
    } t_state;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  qry_init;
        logic  clear;
        logic  scan_start;
        logic  qscan_init;
        logic  scan_run;
        logic  scan_q;
        logic  mem_res;
        logic  shift_init;
        logic  rd_shift;
        logic  wr_shift;
        logic  rec_ins;
        logic  res_ins;
        logic  mul;
        logic  div_start;
        logic  val_latch;
        logic  med_rd;
        logic  out_push;
        t_rsel rsel;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic scan_done;
        logic found;
        logic sh_more;
        logic passes_zero;
        logic n_zero;
        logic div_busy;
        logic tr_zero;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* sv/imf_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface imf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [7:0]         filter_code;
    logic signed [15:0] temperature;
    logic signed [31:0] position;

    modport source (output valid, op, filter_code, temperature, position, input ready);
    modport sink   (input valid, op, filter_code, temperature, position, output ready);
endinterface
`default_nettype wire

/* sv/imf_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface imf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_out;
    logic [1:0]         status;

    modport source (output valid, position_out, status, input ready);
    modport sink   (input valid, position_out, status, output ready);
endinterface
`default_nettype wire

/* sv/interp_median_focus_table.sv */
// Channel  Direction  Contents
// i_in     sink       op, filter_code, temperature, position
// o_out    source     position_out, status (one per input transaction)
// APB      slave      max_pairs at byte address 0
//
// One transaction at a time. Insert scans the table for the insert point, then
// shifts the records above it up and writes the new one; query runs per pass a
// table scan, a 50-step divider and a sorted insert into the result list, then
// reads the median. Each memory has one read port and one write port.
// Reset empties the table and sets max_pairs to 32; no clearing pass.
// A waiting result does not block the next input transaction.
`timescale 1ns / 1ps
`default_nettype none
module interp_median_focus_table
    import imf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    imf_in_if.sink           i_in,
    imf_out_if.source        o_out,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [5:0] r_max_pairs;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pairs <= 6'd32;
        end else if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
            r_max_pairs <= i_pwdata[5:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[2] ? 32'd0 : {26'd0, r_max_pairs};
    assign i_in.ready = w_cmd.in_ready;

    imf_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    imf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_in.op),
        .i_filter_code (i_in.filter_code),
        .i_temperature (i_in.temperature),
        .i_position    (i_in.position),
        .i_max_pairs   (r_max_pairs),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_pos     (o_out.position_out),
        .o_out_status  (o_out.status)
    );

endmodule
`default_nettype wire

/* sv/imf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module imf_div
    import imf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [PROD_W-1:0] i_num,
    input  wire logic signed [TR_W-1:0]   i_den,
    output logic                          o_busy,
    output logic signed [PROD_W-1:0]      o_quot
);

    logic [PROD_W-1:0] r_a;
    logic [TR_W-1:0]   r_d;
    logic [TR_W-1:0]   r_r;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_neg;

    logic [TR_W:0]     w_trial;
    logic [TR_W:0]     w_diff;
    logic              w_ge;
    logic [PROD_W-1:0] w_num_abs;
    logic [TR_W-1:0]   w_den_abs;

    // Take magnitudes, shift one quotient bit per cycle
    always_comb begin
        w_num_abs = i_num[PROD_W-1] ? PROD_W'(-i_num) : PROD_W'(i_num);
        w_den_abs = i_den[TR_W-1] ? TR_W'(-i_den) : TR_W'(i_den);
        w_trial   = {r_r, r_a[PROD_W-1]};
        w_ge      = w_trial >= {1'b0, r_d};
        w_diff    = w_trial - {1'b0, r_d};
    end

    // Sequence the restoring steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == DCNT_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= w_num_abs;
            r_d   <= w_den_abs;
            r_r   <= '0;
            r_cnt <= DCNT_W'(PROD_W);
            r_neg <= i_num[PROD_W-1] ^ i_den[TR_W-1];
        end else if (r_busy) begin
            r_a   <= {r_a[PROD_W-2:0], w_ge};
            r_r   <= w_ge ? w_diff[TR_W-1:0] : w_trial[TR_W-1:0];
            r_cnt <= r_cnt - DCNT_W'(1);
        end
    end

    // Restore the sign, truncating toward zero
    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed(r_a) : $signed(r_a);

endmodule
`default_nettype wire

/* sv/imf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module imf_dp
    import imf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [1:0]         i_op,
    input  wire logic [7:0]         i_filter_code,
    input  wire logic signed [15:0] i_temperature,
    input  wire logic signed [31:0] i_position,
    input  wire logic [5:0]         i_max_pairs,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_out_pos,
    output logic [1:0]              o_out_status
);

    // Latched transaction
    t_op                r_op;
    logic [7:0]         r_f;
    logic signed [15:0] r_t;
    logic signed [31:0] r_p;

    logic [CNT_W-1:0]   r_count;
    logic [N_W-1:0]     r_n;
    logic [5:0]         r_passes;

    // Scan and shift control
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_kd;
    logic               r_rv;
    logic               r_ff;
    logic [CNT_W-1:0]   r_at;
    logic [CNT_W-1:0]   r_j;

    // Query bracket trackers
    logic               r_found, r_loset, r_brk;
    logic signed [15:0] r_fst_t, r_lst_t, r_lo_t, r_hi_t;
    logic signed [31:0] r_fst_p, r_lst_p, r_lo_p, r_hi_p;
    logic signed [TR_W-1:0] r_lt, r_ht;

    // Arithmetic registers
    logic signed [TR_W-1:0]   r_tr;
    logic signed [15:0]       r_tlo, r_thi;
    logic signed [31:0]       r_plo;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [31:0]       r_val;

    // Memories
    logic [REC_W-1:0] m_rec [DEPTH];
    logic [31:0]      m_res [RES_DEPTH];
    logic [REC_W-1:0] r_rec_q;
    logic [31:0]      r_res_q;

    logic               r_out_valid;
    logic signed [31:0] r_out_pos;
    logic [1:0]         r_out_status;

    logic [CNT_W-1:0]   w_limit;
    logic               w_issue;
    logic [CNT_W-1:0]   w_jm1;
    logic [7:0]         w_df;
    logic signed [15:0] w_dt;
    logic signed [31:0] w_dp;
    logic               w_greater;
    logic               w_match;
    logic signed [15:0] w_tlo, w_thi;
    logic signed [31:0] w_plo, w_phi;
    logic signed [TR_W-1:0] w_tv;
    logic signed [PR_W-1:0] w_pr;
    logic signed [TR_W-1:0] w_dt17;
    logic signed [PROD_W-1:0] w_quot;
    logic               w_div_busy;
    logic signed [PROD_W:0] w_sum;
    logic signed [31:0] w_sat;
    logic [5:0]         w_lim;
    logic [5:0]         w_cnt2;
    logic               w_rec_re, w_res_re, w_rec_we, w_res_we;
    logic [REC_AW-1:0]  w_rec_ra, w_rec_wa;
    logic [RES_AW-1:0]  w_res_ra, w_res_wa;
    logic [REC_W-1:0]   w_rec_wd;
    logic [31:0]        w_res_wd;

    // Decode read data and the chosen bracket
    always_comb begin
        w_limit  = i_cmd.mem_res ? CNT_W'(r_n) : r_count;
        w_issue  = i_cmd.scan_run && (r_k < w_limit);
        w_jm1    = r_j - CNT_W'(1);
        w_df     = r_rec_q[REC_W-1 -: 8];
        w_dt     = $signed(r_rec_q[47:32]);
        w_dp     = $signed(r_rec_q[31:0]);
        w_dt17   = TR_W'(w_dt);
        w_match  = w_df == r_f;
        w_greater = i_cmd.mem_res ? ($signed(r_res_q) > r_val) : (w_dt > r_t);
        w_tlo    = r_loset ? r_lo_t : r_fst_t;
        w_plo    = r_loset ? r_lo_p : r_fst_p;
        w_thi    = r_brk ? r_hi_t : r_lst_t;
        w_phi    = r_brk ? r_hi_p : r_lst_p;
        w_tv     = TR_W'(r_t) - TR_W'(w_tlo);
        w_pr     = PR_W'(w_phi) - PR_W'(w_plo);
        w_sum    = (PROD_W+1)'(r_plo) + (r_tr == '0 ? '0 : (PROD_W+1)'(w_quot));
        if (w_sum > (PROD_W+1)'(32'sh7fffffff)) begin
            w_sat = 32'sh7fffffff;
        end else if (w_sum < -(PROD_W+1)'(33'sh080000000)) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_sum[31:0];
        end
        w_lim    = (i_max_pairs > 6'(RES_DEPTH)) ? 6'(RES_DEPTH) : i_max_pairs;
        w_cnt2   = 6'(r_count >> 1);
    end

    // Memory ports
    always_comb begin
        w_rec_re = (w_issue && !i_cmd.mem_res) || (i_cmd.rd_shift && !i_cmd.mem_res);
        w_rec_ra = i_cmd.rd_shift ? w_jm1[REC_AW-1:0] : r_k[REC_AW-1:0];
        w_rec_we = (i_cmd.wr_shift && !i_cmd.mem_res) || i_cmd.rec_ins;
        w_rec_wa = i_cmd.rec_ins ? r_at[REC_AW-1:0] : r_j[REC_AW-1:0];
        w_rec_wd = i_cmd.rec_ins ? {r_f, r_t, r_p} : r_rec_q;
        w_res_re = (w_issue && i_cmd.mem_res) || (i_cmd.rd_shift && i_cmd.mem_res)
                   || i_cmd.med_rd;
        w_res_ra = i_cmd.med_rd ? r_n[RES_AW:1] :
                   (i_cmd.rd_shift ? w_jm1[RES_AW-1:0] : r_k[RES_AW-1:0]);
        w_res_we = (i_cmd.wr_shift && i_cmd.mem_res) || i_cmd.res_ins;
        w_res_wa = i_cmd.res_ins ? r_at[RES_AW-1:0] : r_j[RES_AW-1:0];
        w_res_wd = i_cmd.res_ins ? r_val : r_res_q;
    end

    always_ff @(posedge i_clk) begin
        if (w_rec_we) begin
            m_rec[w_rec_wa] <= w_rec_wd;
        end
        if (w_rec_re) begin
            r_rec_q <= m_rec[w_rec_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            m_res[w_res_wa] <= w_res_wd;
        end
        if (w_res_re) begin
            r_res_q <= m_res[w_res_ra];
        end
    end

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rv    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.rec_ins) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_rv <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_rv <= w_issue;
            end
        end
    end

    // Hold the transaction and walk the scans
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_op);
            r_f  <= i_filter_code;
            r_t  <= i_temperature;
            r_p  <= i_position;
        end
        if (i_cmd.scan_start) begin
            r_k  <= '0;
            r_ff <= 1'b0;
            r_at <= w_limit;
        end else if (i_cmd.scan_run) begin
            if (w_issue) begin
                r_k <= r_k + CNT_W'(1);
            end
            r_kd <= r_k;
            if (r_rv && !i_cmd.scan_q && !r_ff && w_greater) begin
                r_at <= r_kd;
                r_ff <= 1'b1;
            end
        end
        if (i_cmd.shift_init) begin
            r_j <= w_limit;
        end else if (i_cmd.wr_shift) begin
            r_j <= w_jm1;
        end
    end

    // Track first, last and bracketing records of the filter
    always_ff @(posedge i_clk) begin
        if (i_cmd.qscan_init) begin
            r_found <= 1'b0;
            r_loset <= 1'b0;
            r_brk   <= 1'b0;
        end else if (i_cmd.scan_run && i_cmd.scan_q && r_rv && w_match) begin
            r_found <= 1'b1;
            if (!r_found) begin
                r_fst_t <= w_dt;
                r_fst_p <= w_dp;
            end
            r_lst_t <= w_dt;
            r_lst_p <= w_dp;
            if (!r_brk) begin
                if (w_dt17 <= r_lt) begin
                    r_loset <= 1'b1;
                    r_lo_t  <= w_dt;
                    r_lo_p  <= w_dp;
                end
                if (w_dt17 >= r_ht) begin
                    r_brk  <= 1'b1;
                    r_hi_t <= w_dt;
                    r_hi_p <= w_dp;
                end
            end
        end
    end

    // Interpolate and step the passes
    always_ff @(posedge i_clk) begin
        if (i_cmd.qry_init) begin
            r_n      <= '0;
            r_lt     <= TR_W'(r_t);
            r_ht     <= TR_W'(r_t);
            r_passes <= (w_cnt2 > w_lim) ? w_lim : w_cnt2;
        end else if (i_cmd.res_ins) begin
            r_n      <= r_n + N_W'(1);
            r_passes <= r_passes - 6'd1;
            r_lt     <= TR_W'(r_tlo) - TR_W'(1);
            r_ht     <= TR_W'(r_thi) + TR_W'(1);
        end
        if (i_cmd.mul) begin
            r_tr   <= TR_W'(w_thi) - TR_W'(w_tlo);
            r_tlo  <= w_tlo;
            r_thi  <= w_thi;
            r_plo  <= w_plo;
            r_prod <= PROD_W'(w_tv * w_pr);
        end
        if (i_cmd.val_latch) begin
            r_val <= w_sat;
        end
    end

    imf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start && r_tr != '0),
        .i_num   (r_prod),
        .i_den   (r_tr),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_push) begin
            case (i_cmd.rsel)
                RS_OK: begin
                    r_out_pos    <= '0;
                    r_out_status <= ST_OK;
                end
                RS_FULL: begin
                    r_out_pos    <= '0;
                    r_out_status <= ST_FULL;
                end
                RS_NODATA: begin
                    r_out_pos    <= '0;
                    r_out_status <= ST_NODATA;
                end
                RS_MEDIAN: begin
                    r_out_pos    <= $signed(r_res_q);
                    r_out_status <= ST_OK;
                end
                default: begin
                    r_out_pos    <= '0;
                    r_out_status <= ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_pos    = r_out_pos;
    assign o_out_status = r_out_status;

    // Status to the controller
    always_comb begin
        o_sts.op          = r_op;
        o_sts.full        = r_count == CNT_W'(DEPTH);
        o_sts.scan_done   = (r_k == w_limit) && !r_rv;
        o_sts.found       = r_found;
        o_sts.sh_more     = r_j > r_at;
        o_sts.passes_zero = r_passes == '0;
        o_sts.n_zero      = r_n == '0;
        o_sts.div_busy    = w_div_busy;
        o_sts.tr_zero     = r_tr == '0;
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("record count beyond table depth");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rec_ins |-> r_count < CNT_W'(DEPTH))
        else $error("record insert into full table");
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_ins |-> r_n < N_W'(RES_DEPTH))
        else $error("result insert into full list");
    a_shift_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_shift |-> r_j > r_at)
        else $error("shift write at or below insert point");

endmodule
`default_nettype wire

/* sv/imf_ctl.sv */
`timescale 1ns / 1ps
`default_nettype none
module imf_ctl
    import imf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_INSERT: n_state = i_sts.full ? S_FIN_FULL : S_ISCAN;
                    OP_QUERY:  n_state = S_PASS;
                    default:   n_state = S_FIN_OK;
                endcase
            end
            S_ISCAN: begin
                if (i_sts.scan_done) n_state = S_ISH_RD;
            end
            S_ISH_RD: begin
                n_state = i_sts.sh_more ? S_ISH_WR : S_FIN_OK;
            end
            S_ISH_WR: n_state = S_ISH_RD;
            S_PASS: begin
                if (i_sts.passes_zero) begin
                    n_state = i_sts.n_zero ? S_FIN_NODATA : S_MRD;
                end else begin
                    n_state = S_QSCAN;
                end
            end
            S_QSCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.found) n_state = S_MUL;
                    else n_state = i_sts.n_zero ? S_FIN_NODATA : S_MRD;
                end
            end
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (!i_sts.div_busy || i_sts.tr_zero) n_state = S_RSCAN;
            end
            S_RSCAN: begin
                if (i_sts.scan_done) n_state = S_RSH_RD;
            end
            S_RSH_RD: begin
                n_state = i_sts.sh_more ? S_RSH_WR : S_PASS;
            end
            S_RSH_WR: n_state = S_RSH_RD;
            S_MRD:    n_state = S_FIN_MED;
            S_FIN_OK, S_FIN_FULL, S_FIN_NODATA, S_FIN_MED: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.rsel = RS_OK;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_INSERT: o_cmd.scan_start = 1'b1;
                    OP_QUERY:  o_cmd.qry_init   = 1'b1;
                    OP_CLEAR:  o_cmd.clear      = 1'b1;
                    default:   o_cmd.clear      = 1'b0;
                endcase
            end
            S_ISCAN: begin
                o_cmd.scan_run   = 1'b1;
                o_cmd.shift_init = i_sts.scan_done;
            end
            S_ISH_RD: begin
                o_cmd.rd_shift = i_sts.sh_more;
                o_cmd.rec_ins  = !i_sts.sh_more;
            end
            S_ISH_WR: o_cmd.wr_shift = 1'b1;
            S_PASS: begin
                o_cmd.scan_start = !i_sts.passes_zero;
                o_cmd.qscan_init = !i_sts.passes_zero;
                o_cmd.scan_q     = 1'b1;
            end
            S_QSCAN: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.scan_q   = 1'b1;
            end
            S_MUL:   o_cmd.mul       = 1'b1;
            S_DIVGO: o_cmd.div_start = 1'b1;
            S_DIV: begin
                o_cmd.mem_res    = 1'b1;
                o_cmd.val_latch  = !i_sts.div_busy || i_sts.tr_zero;
                o_cmd.scan_start = !i_sts.div_busy || i_sts.tr_zero;
            end
            S_RSCAN: begin
                o_cmd.mem_res    = 1'b1;
                o_cmd.scan_run   = 1'b1;
                o_cmd.shift_init = i_sts.scan_done;
            end
            S_RSH_RD: begin
                o_cmd.mem_res  = 1'b1;
                o_cmd.rd_shift = i_sts.sh_more;
                o_cmd.res_ins  = !i_sts.sh_more;
            end
            S_RSH_WR: begin
                o_cmd.mem_res  = 1'b1;
                o_cmd.wr_shift = 1'b1;
            end
            S_MRD: o_cmd.med_rd = 1'b1;
            S_FIN_OK: begin
                o_cmd.out_push = i_sts.out_free;
                o_cmd.rsel     = RS_OK;
            end
            S_FIN_FULL: begin
                o_cmd.out_push = i_sts.out_free;
                o_cmd.rsel     = RS_FULL;
            end
            S_FIN_NODATA: begin
                o_cmd.out_push = i_sts.out_free;
                o_cmd.rsel     = RS_NODATA;
            end
            S_FIN_MED: begin
                o_cmd.out_push = i_sts.out_free;
                o_cmd.rsel     = RS_MEDIAN;
            end
            default: o_cmd.rsel = RS_OK;
        endcase
    end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import imf_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int STALL_PCT  = 36;
    localparam int IDLE_LIMIT = 100000;

    typedef struct packed {
        t_op                op;
        logic [7:0]         filter_code;
        logic signed [15:0] temperature;
        logic signed [31:0] position;
    } focus_cmd_t;

    // Focus table predictor and queue of expected answers
    class focus_scoreboard;
        logic [7:0] rec_flt[DEPTH];
        int         rec_temp[DEPTH];
        int         rec_pos[DEPTH];
        int         rec_cnt;
        int         pair_limit;
        int         want_pos[$];
        logic [1:0] want_st[$];
        int         mismatches;

        function new();
            rec_cnt    = 0;
            pair_limit = 32;
            mismatches = 0;
        endfunction

        function void set_pairs(int value);
            pair_limit = value & 63;
        endfunction

        // Place a record after every record of equal or lower temperature
        function void add_record(logic [7:0] f, int t, int p);
            int at;
            at = 0;
            while (at < rec_cnt && rec_temp[at] <= t) at++;
            for (int i = rec_cnt; i > at; i--) begin
                rec_flt[i]  = rec_flt[i-1];
                rec_temp[i] = rec_temp[i-1];
                rec_pos[i]  = rec_pos[i-1];
            end
            rec_flt[at]  = f;
            rec_temp[at] = t;
            rec_pos[at]  = p;
            rec_cnt++;
        endfunction

        // Median of the outward interpolation passes; returns 0 on no data
        function bit median_focus(logic [7:0] f, int t, output int med);
            int     passes, lim, n, lt, ht, lo, hi, e, val;
            int     list[RES_DEPTH];
            longint tr, pr, tv, v;
            passes = rec_cnt / 2;
            lim    = (pair_limit > RES_DEPTH) ? RES_DEPTH : pair_limit;
            if (passes > lim) passes = lim;
            n   = 0;
            lt  = t;
            ht  = t;
            med = 0;
            for (int ps = 0; ps < passes; ps++) begin
                lo = -1;
                hi = -1;
                for (int k = 0; k < rec_cnt; k++)
                    if (rec_flt[k] == f) begin lo = k; break; end
                for (int k = rec_cnt - 1; k >= 0; k--)
                    if (rec_flt[k] == f) begin hi = k; break; end
                if (lo < 0) break;
                for (int k = 0; k < rec_cnt; k++) begin
                    if (rec_flt[k] != f) continue;
                    if (rec_temp[k] <= lt) lo = k;
                    if (rec_temp[k] >= ht) begin hi = k; break; end
                end
                tr = longint'(rec_temp[hi]) - longint'(rec_temp[lo]);
                pr = longint'(rec_pos[hi]) - longint'(rec_pos[lo]);
                tv = longint'(t) - longint'(rec_temp[lo]);
                v  = rec_pos[lo];
                if (tr != 0) v += (tv * pr) / tr;
                if (v > 64'sd2147483647) val = 32'h7fffffff;
                else if (v < -64'sd2147483648) val = 32'h80000000;
                else val = int'(v);
                e = 0;
                while (e < n && list[e] <= val) e++;
                for (int i = n; i > e; i--) list[i] = list[i-1];
                list[e] = val;
                n++;
                lt = rec_temp[lo] - 1;
                ht = rec_temp[hi] + 1;
            end
            if (n == 0) return 0;
            med = list[n/2];
            return 1;
        endfunction

        // Note an accepted input transaction and queue its answer
        function void note_cmd(focus_cmd_t c);
            int         res;
            logic [1:0] st;
            res = 0;
            st  = ST_OK;
            case (c.op)
                OP_INSERT: begin
                    if (rec_cnt >= DEPTH) st = ST_FULL;
                    else add_record(c.filter_code, c.temperature, c.position);
                end
                OP_QUERY: begin
                    if (!median_focus(c.filter_code, c.temperature, res)) begin
                        res = 0;
                        st  = ST_NODATA;
                    end
                end
                OP_CLEAR: rec_cnt = 0;
                default: ;
            endcase
            want_pos.push_back(res);
            want_st.push_back(st);
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endfunction

        // Compare an accepted answer with the oldest expectation
        function void check_answer(logic signed [31:0] p, logic [1:0] st);
            int         ep;
            logic [1:0] es;
            if (want_pos.size() == 0) begin
                report($sformatf("unexpected answer pos=%0d st=%0d", p, st));
                return;
            end
            ep = want_pos.pop_front();
            es = want_st.pop_front();
            if (st !== es)
                report($sformatf("status got %0d want %0d", st, es));
            if (p !== ep)
                report($sformatf("position got %0d want %0d", p, ep));
        endfunction

        function int pending();
            return want_pos.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;
    bit          no_stall;
    int          idle_cycles;

    imf_in_if  in_if();
    imf_out_if out_if();

    focus_scoreboard sb = new();

    interp_median_focus_table i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Stall the answer side at random
    always @(posedge i_clk) begin
        out_if.ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
    end

    // Track transactions on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_cmd({t_op'(in_if.op), in_if.filter_code, in_if.temperature,
                         in_if.position});
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_answer(out_if.position_out, out_if.status);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (i_psel && i_penable) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_cmd(focus_cmd_t c);
        while (!no_stall && $urandom_range(99) < STALL_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= c.op;
        in_if.filter_code <= c.filter_code;
        in_if.temperature <= c.temperature;
        in_if.position    <= c.position;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send(t_op op, int f, int t, int p);
        send_cmd({op, 8'(f), 16'(t), 32'(p)});
    endtask

    // Hold until every answer has come, then let the block settle
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_pairs(int value);
        drain();
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= 3'd0;
        i_pwdata  <= 32'(value);
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_pairs(value);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic focus_cmd_t rand_cmd(int ins_pct);
        focus_cmd_t c;
        int         r;
        r = $urandom_range(99);
        if (r < ins_pct) c.op = OP_INSERT;
        else if (r < 94) c.op = OP_QUERY;
        else if (r < 97) c.op = OP_CLEAR;
        else c.op = OP_NONE;
        c.filter_code = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        c.temperature = ($urandom_range(7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(400) - 200);
        c.position    = ($urandom_range(3) == 0) ? 32'($urandom)
                                                 : 32'($urandom_range(20000) - 10000);
        return c;
    endfunction

    task automatic random_run(int count, int ins_pct);
        for (int i = 0; i < count; i++) send_cmd(rand_cmd(ins_pct));
    endtask

    initial begin
        in_if.valid       = 1'b0;
        in_if.op          = OP_NONE;
        in_if.filter_code = '0;
        in_if.temperature = '0;
        in_if.position    = '0;
        out_if.ready      = 1'b0;
        i_psel            = 1'b0;
        i_penable         = 1'b0;
        i_pwrite          = 1'b0;
        i_paddr           = '0;
        i_pwdata          = '0;
        no_stall          = 1'b0;
        idle_cycles       = 0;
        i_rst_n           = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, saturation, equal temperatures
        send(OP_QUERY, 0, 0, 0);
        send(OP_INSERT, 0, -32768, 32'h80000000);
        send(OP_INSERT, 0, 32767, 32'h7fffffff);
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, -32768, 5);
        send(OP_QUERY, 0, 32767, -5);
        send(OP_QUERY, 255, 100, 0);
        send(OP_INSERT, 1, 0, 0);
        send(OP_INSERT, 1, 1, 32'h7fffffff);
        send(OP_QUERY, 1, 32767, 0);
        send(OP_QUERY, 1, -32768, 0);
        send(OP_INSERT, 255, 50, 1234);
        send(OP_INSERT, 255, 50, -4321);
        send(OP_QUERY, 255, 50, 0);
        send(OP_QUERY, 255, -7, 0);
        send(OP_NONE, 255, -1, -1);
        send(OP_CLEAR, 0, 0, 0);
        send(OP_QUERY, 0, 0, 0);
        send(OP_INSERT, 3, 10, 100);
        send(OP_QUERY, 3, 10, 0);

        // Pass limits at both ends and past the range
        write_pairs(1);
        send(OP_INSERT, 3, 30, 300);
        send(OP_QUERY, 3, 20, 0);
        write_pairs(0);
        send(OP_QUERY, 3, 20, 0);
        write_pairs(63);
        random_run(6, 55);

        // Fill the table past its depth, then query the full table
        send(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < DEPTH + 2; i++) send_cmd(rand_cmd(100));
        random_run(3, 0);

        // Quiet stretch without any stalls on either side
        write_pairs(32);
        no_stall = 1'b1;
        random_run(8, 50);
        drain();
        no_stall = 1'b0;

        write_pairs($urandom_range(32, 1));
        random_run(5, 50);
        write_pairs(5);
        random_run(4, 45);

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
